// ===== sv/cecbif_pkg.sv =====
// Shared types, codes and timing constants for the CEC bus engine.
`default_nettype none
package cecbif_pkg;

    typedef enum logic [4:0] {
        PH_DIS         = 5'd0,
        PH_IDLE        = 5'd1,
        PH_WAIT_FREE   = 5'd2,
        PH_TX_START_LO = 5'd3,
        PH_TX_START_HI = 5'd4,
        PH_TX_INIT_LO  = 5'd5,
        PH_TX_INIT_HI  = 5'd6,
        PH_TX_DST_LO   = 5'd7,
        PH_TX_DST_HI   = 5'd8,
        PH_TX_DAT_LO   = 5'd9,
        PH_TX_DAT_HI   = 5'd10,
        PH_TX_EOM_LO   = 5'd11,
        PH_TX_EOM_HI   = 5'd12,
        PH_TX_ACK_LO   = 5'd13,
        PH_TX_ACK_WAIT = 5'd14,
        PH_TX_ACK_SMP  = 5'd15,
        PH_RX_START_LO = 5'd16,
        PH_RX_START_HI = 5'd17,
        PH_RX_DEBOUNCE = 5'd18,
        PH_RX_INIT_LO  = 5'd19,
        PH_RX_INIT_HI  = 5'd20,
        PH_RX_DST_LO   = 5'd21,
        PH_RX_DST_HI   = 5'd22,
        PH_RX_EOM_LO   = 5'd23,
        PH_RX_EOM_HI   = 5'd24,
        PH_RX_ACK_DRV  = 5'd25,
        PH_RX_ACK_CHK  = 5'd26,
        PH_RX_ACK_DONE = 5'd27,
        PH_RX_DAT_LO   = 5'd28,
        PH_RX_DAT_HI   = 5'd29
    } phase_t;

    localparam logic [2:0] OP_TIMER = 3'd0;
    localparam logic [2:0] OP_EDGE  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_SEND  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_RISE = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_RX_DONE = 2'd1;
    localparam logic [1:0] EV_TX_OK   = 2'd2;
    localparam logic [1:0] EV_TX_FAIL = 2'd3;

    localparam int F_ACK = 0;
    localparam int F_PI  = 1;
    localparam int F_EOM = 2;
    localparam int F_NAK = 3;

    localparam logic [3:0] BCAST = 4'hf;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] capture_ticks;
        logic        bus_level;
        logic [3:0]  byte_index;
        logic [7:0]  byte_value;
        logic [4:0]  msg_length;
    } item_t;

    typedef struct packed {
        logic        line_level;
        logic        timer_start;
        logic [13:0] timer_ticks;
        logic [1:0]  edge_select;
        logic [1:0]  event_code;
        logic        busy_error;
        logic [4:0]  rx_length;
        logic [7:0]  rx_byte;
        logic [4:0]  protocol_state;
    } result_t;

    typedef struct packed {
        logic en_wr;
        logic en;
    } cfg_cmd_t;

    function automatic logic [13:0] low_of(input logic one);
        return one ? 14'd600 : 14'd1500;
    endfunction

    function automatic logic [13:0] high_of(input logic one);
        return one ? 14'd1800 : 14'd900;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cecbif_engine.sv =====
// Protocol state, buffers and single-pass event logic of the CEC bus engine.
`default_nettype none
module cecbif_engine #(
    parameter int MSG_BYTES   = 16,
    parameter int MAX_RESENDS = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire cecbif_pkg::item_t   item,
    input  wire cecbif_pkg::cfg_cmd_t cfg,
    input  wire logic [7:0]          own_address,
    output cecbif_pkg::result_t      result
);
    import cecbif_pkg::*;

    localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam logic [4:0] NB = 5'(MSG_BYTES);
    localparam logic [2:0] NR = 3'(MAX_RESENDS);

    phase_t      phase_reg, ph;
    logic [7:0]  txbuf_reg [MSG_BYTES];
    logic [7:0]  rxbuf_reg [MSG_BYTES];
    logic [7:0]  rxbuf_next [MSG_BYTES];
    logic [4:0]  txlen_reg, txlen;
    logic [2:0]  txbit_reg, txbit;
    logic [4:0]  txbyte_reg, txbyte;
    logic [2:0]  rxbit_reg, rxbit;
    logic [4:0]  rxbyte_reg, rxbyte;
    logic [2:0]  rcnt_reg, rcnt;
    logic [3:0]  flags_reg, flags;
    logic [15:0] lowt_reg, lowt;
    logic [1:0]  dh_reg, dh;
    logic        line_reg, line;

    logic        tx_wr;
    logic        go;
    phase_t      tgt;
    logic        start;
    logic [1:0]  edge_sel;
    logic [13:0] ticks;
    logic [1:0]  evt;
    logic        busy;
    logic [7:0]  rbyte;
    logic        b;
    logic        tb;
    logic        eom;
    logic        zl, ol;
    logic [16:0] d;
    logic [15:0] t;
    logic        clear_rx;

    always_comb begin
        ph = phase_reg;
        txlen = txlen_reg;
        txbit = txbit_reg;
        txbyte = txbyte_reg;
        rxbit = rxbit_reg;
        rxbyte = rxbyte_reg;
        rcnt = rcnt_reg;
        flags = flags_reg;
        lowt = lowt_reg;
        dh = dh_reg;
        line = line_reg;
        rxbuf_next = rxbuf_reg;
        tx_wr = 1'b0;
        go = 1'b0;
        tgt = PH_IDLE;
        start = 1'b0;
        edge_sel = EDGE_NONE;
        ticks = '0;
        evt = EV_NONE;
        busy = 1'b0;
        rbyte = '0;
        b = 1'b0;
        tb = 1'b0;
        eom = 1'b0;
        clear_rx = 1'b0;
        t = item.capture_ticks;
        zl = (t >= 16'd1200) && (t <= 16'd1800);
        ol = (t >= 16'd300) && (t <= 16'd900);
        d = {1'b0, lowt_reg} + {1'b0, t};

        if (cfg.en_wr) begin
            if (cfg.en && phase_reg == PH_DIS) begin
                go = 1'b1;
                tgt = PH_IDLE;
            end else if (!cfg.en && phase_reg != PH_DIS) begin
                go = 1'b1;
                tgt = PH_DIS;
            end
        end else if (step) begin
            case (item.op)
                OP_TIMER: begin
                    case (phase_reg)
                        PH_DIS, PH_IDLE: ;
                        PH_TX_INIT_HI, PH_TX_DST_HI, PH_TX_DAT_HI: begin
                            txbit = txbit + 3'd1;
                            if (txbit == 3'd0 && txbyte < NB) begin
                                txbyte = txbyte + 5'd1;
                            end
                            go = 1'b1;
                            if (phase_reg == PH_TX_INIT_HI) begin
                                tgt = (txbit == 3'd4) ? PH_TX_DST_LO : PH_TX_INIT_LO;
                            end else if (phase_reg == PH_TX_DST_HI) begin
                                tgt = (txbyte == 5'd1) ? PH_TX_EOM_LO : PH_TX_DST_LO;
                            end else begin
                                tgt = (txbit == 3'd0) ? PH_TX_EOM_LO : PH_TX_DAT_LO;
                            end
                        end
                        PH_TX_ACK_SMP: begin
                            go = 1'b1;
                            if (flags[F_ACK]) begin
                                if (!(txbit == 3'd0 && txbyte == txlen)) begin
                                    tgt = PH_TX_DAT_LO;
                                end else begin
                                    txlen = '0;
                                    rcnt = '0;
                                    tgt = PH_IDLE;
                                    evt = EV_TX_OK;
                                end
                            end else if (rcnt < NR) begin
                                rcnt = rcnt + 3'd1;
                                tgt = PH_WAIT_FREE;
                            end else begin
                                txlen = '0;
                                rcnt = '0;
                                tgt = PH_IDLE;
                                evt = EV_TX_FAIL;
                            end
                        end
                        PH_WAIT_FREE, PH_TX_START_LO, PH_TX_START_HI, PH_TX_INIT_LO,
                        PH_TX_DST_LO, PH_TX_DAT_LO, PH_TX_EOM_LO, PH_TX_EOM_HI,
                        PH_TX_ACK_LO, PH_TX_ACK_WAIT, PH_RX_ACK_DRV: begin
                            go = 1'b1;
                            tgt = phase_t'(phase_reg + 5'd1);
                        end
                        PH_RX_ACK_CHK: begin
                            go = 1'b1;
                            tgt = flags[F_NAK] ? PH_IDLE : PH_RX_ACK_DONE;
                        end
                        default: begin
                            go = 1'b1;
                            tgt = PH_IDLE;
                        end
                    endcase
                end
                OP_EDGE: begin
                    case (phase_reg)
                        PH_IDLE: begin
                            go = 1'b1;
                            tgt = PH_RX_START_LO;
                        end
                        PH_WAIT_FREE, PH_TX_START_HI, PH_TX_INIT_HI: begin
                            txbit = '0;
                            txbyte = '0;
                            go = 1'b1;
                            tgt = PH_RX_START_LO;
                        end
                        PH_RX_START_LO: begin
                            go = 1'b1;
                            if (t >= 16'd3400 && t <= 16'd4000) begin
                                lowt = t;
                                tgt = PH_RX_START_HI;
                            end else if (t < 16'd200) begin
                                tgt = PH_RX_DEBOUNCE;
                            end else begin
                                tgt = PH_IDLE;
                            end
                        end
                        PH_RX_START_HI: begin
                            go = 1'b1;
                            tgt = (d >= 17'd4200 && d <= 17'd5800) ? PH_RX_INIT_LO : PH_IDLE;
                        end
                        PH_RX_INIT_LO, PH_RX_DST_LO, PH_RX_DAT_LO: begin
                            go = 1'b1;
                            if (zl || ol) begin
                                lowt = t;
                                if (rxbyte < NB) begin
                                    rxbuf_next[rxbyte[AW-1:0]][3'd7 - rxbit] = !zl;
                                end
                                tgt = phase_t'(phase_reg + 5'd1);
                            end else begin
                                tgt = PH_IDLE;
                            end
                        end
                        PH_RX_INIT_HI, PH_RX_DST_HI, PH_RX_DAT_HI: begin
                            go = 1'b1;
                            if (d >= 17'd1950 && d <= 17'd2850) begin
                                rxbit = rxbit + 3'd1;
                                if (rxbit == 3'd0 && rxbyte < NB) begin
                                    rxbyte = rxbyte + 5'd1;
                                end
                                if (phase_reg == PH_RX_INIT_HI) begin
                                    tgt = (rxbit == 3'd4) ? PH_RX_DST_LO : PH_RX_INIT_LO;
                                end else if (rxbit == 3'd0) begin
                                    tgt = PH_RX_EOM_LO;
                                end else begin
                                    tgt = (phase_reg == PH_RX_DST_HI) ? PH_RX_DST_LO
                                                                      : PH_RX_DAT_LO;
                                end
                            end else begin
                                tgt = PH_IDLE;
                            end
                        end
                        PH_RX_EOM_LO: begin
                            go = 1'b1;
                            if (zl || ol) begin
                                lowt = t;
                                flags[F_EOM] = !zl;
                                tgt = PH_RX_EOM_HI;
                            end else begin
                                tgt = PH_IDLE;
                            end
                        end
                        PH_RX_EOM_HI: begin
                            go = 1'b1;
                            tgt = (d >= 17'd1950 && d <= 17'd2850) ? PH_RX_ACK_DRV : PH_IDLE;
                        end
                        PH_RX_ACK_DRV: begin
                            go = 1'b1;
                            tgt = PH_RX_ACK_DONE;
                        end
                        PH_RX_ACK_DONE: begin
                            go = 1'b1;
                            tgt = PH_RX_DAT_LO;
                        end
                        default: ;
                    endcase
                end
                OP_WRITE: begin
                    tx_wr = (txlen_reg == 5'd0) && ({1'b0, item.byte_index} < NB);
                end
                OP_SEND: begin
                    if (phase_reg == PH_DIS || txlen_reg != 5'd0) begin
                        busy = 1'b1;
                    end else begin
                        txlen = (item.msg_length > NB) ? NB : item.msg_length;
                        if (txlen != 5'd0 && phase_reg == PH_IDLE) begin
                            go = 1'b1;
                            tgt = PH_WAIT_FREE;
                        end
                    end
                end
                OP_READ: begin
                    if ({1'b0, item.byte_index} < NB) begin
                        rbyte = rxbuf_reg[item.byte_index[AW-1:0]];
                    end
                end
                default: ;
            endcase
        end

        if (go) begin
            if (tgt == PH_IDLE) begin
                txbit = '0;
                txbyte = '0;
                rxbit = '0;
                rxbyte = '0;
                if (txlen != 5'd0) begin
                    tgt = PH_WAIT_FREE;
                end
            end
            ph = tgt;
            tb = (txbyte < NB) ? txbuf_reg[txbyte[AW-1:0]][3'd7 - txbit] : 1'b0;
            eom = (txbit == 3'd0) && (txbyte == txlen);
            case (tgt)
                PH_DIS: begin
                    line = 1'b1;
                    clear_rx = 1'b1;
                    txlen = '0;
                    txbit = '0;
                    txbyte = '0;
                    rxbit = '0;
                    rxbyte = '0;
                    rcnt = '0;
                    flags = '0;
                    dh = '0;
                    lowt = '0;
                end
                PH_IDLE: begin
                    line = 1'b1;
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                end
                PH_WAIT_FREE: begin
                    line = 1'b1;
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                    ticks = (rcnt != 3'd0) ? 14'd4800 : (flags[F_PI] ? 14'd14400 : 14'd9600);
                end
                PH_TX_START_LO: begin
                    flags[F_PI] = 1'b1;
                    txbit = '0;
                    txbyte = '0;
                    line = 1'b0;
                    start = 1'b1;
                    ticks = 14'd3700;
                end
                PH_TX_START_HI: begin
                    line = 1'b1;
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                    ticks = 14'd800;
                end
                PH_TX_INIT_LO, PH_TX_DST_LO, PH_TX_DAT_LO: begin
                    line = 1'b0;
                    start = 1'b1;
                    ticks = low_of(tb);
                end
                PH_TX_INIT_HI: begin
                    line = 1'b1;
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                    ticks = high_of(tb);
                end
                PH_TX_DST_HI, PH_TX_DAT_HI: begin
                    line = 1'b1;
                    start = 1'b1;
                    ticks = high_of(tb);
                end
                PH_TX_EOM_LO: begin
                    line = 1'b0;
                    start = 1'b1;
                    ticks = low_of(eom);
                end
                PH_TX_EOM_HI: begin
                    line = 1'b1;
                    start = 1'b1;
                    ticks = high_of(eom);
                end
                PH_TX_ACK_LO: begin
                    line = 1'b0;
                    start = 1'b1;
                    ticks = 14'd600;
                end
                PH_TX_ACK_WAIT: begin
                    line = 1'b1;
                    start = 1'b1;
                    ticks = 14'd450;
                end
                PH_TX_ACK_SMP: begin
                    b = !item.bus_level ^ (txbuf_reg[0][3:0] == BCAST);
                    flags[F_ACK] = b;
                    start = 1'b1;
                    ticks = 14'd1350;
                end
                PH_RX_START_LO: begin
                    flags[F_PI] = 1'b0;
                    start = 1'b1;
                    edge_sel = EDGE_RISE;
                    ticks = 14'd4000;
                end
                PH_RX_START_HI: begin
                    dh = '0;
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                    ticks = 14'd2300;
                end
                PH_RX_DEBOUNCE: begin
                    start = 1'b1;
                    if (dh == 2'd3) begin
                        ticks = 14'd500;
                    end else begin
                        ticks = 14'd100;
                        dh = dh + 2'd1;
                    end
                end
                PH_RX_INIT_LO, PH_RX_DST_LO, PH_RX_EOM_LO, PH_RX_DAT_LO: begin
                    start = 1'b1;
                    edge_sel = EDGE_RISE;
                    ticks = 14'd1800;
                end
                PH_RX_INIT_HI, PH_RX_DST_HI, PH_RX_EOM_HI, PH_RX_DAT_HI: begin
                    start = 1'b1;
                    edge_sel = EDGE_FALL;
                    ticks = 14'd2450;
                end
                PH_RX_ACK_DRV: begin
                    if ({4'd0, rxbuf_next[0][3:0]} == own_address) begin
                        line = 1'b0;
                    end
                    start = 1'b1;
                    ticks = 14'd1050;
                end
                PH_RX_ACK_CHK: begin
                    flags[F_NAK] = (rxbuf_next[0][3:0] == BCAST) && !item.bus_level;
                    start = 1'b1;
                    ticks = 14'd450;
                end
                PH_RX_ACK_DONE: begin
                    line = 1'b1;
                    start = 1'b1;
                    if (flags[F_EOM] || rxbyte >= NB) begin
                        if ({4'd0, rxbuf_next[0][3:0]} == own_address
                            || rxbuf_next[0][3:0] == BCAST) begin
                            evt = EV_RX_DONE;
                        end
                        ticks = 14'd900;
                    end else begin
                        edge_sel = EDGE_FALL;
                        ticks = 14'd2450;
                    end
                end
                default: ;
            endcase
        end

        result.line_level = line;
        result.timer_start = start;
        result.timer_ticks = start ? ticks : 14'd0;
        result.edge_select = start ? edge_sel : EDGE_NONE;
        result.event_code = evt;
        result.busy_error = busy;
        result.rx_length = rxbyte;
        result.rx_byte = rbyte;
        result.protocol_state = ph;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DIS;
            txlen_reg <= '0;
            txbit_reg <= '0;
            txbyte_reg <= '0;
            rxbit_reg <= '0;
            rxbyte_reg <= '0;
            rcnt_reg <= '0;
            flags_reg <= '0;
            lowt_reg <= '0;
            dh_reg <= '0;
            line_reg <= 1'b1;
            for (int i = 0; i < MSG_BYTES; i++) begin
                rxbuf_reg[i] <= '0;
            end
        end else if (step || cfg.en_wr) begin
            phase_reg <= ph;
            txlen_reg <= txlen;
            txbit_reg <= txbit;
            txbyte_reg <= txbyte;
            rxbit_reg <= rxbit;
            rxbyte_reg <= rxbyte;
            rcnt_reg <= rcnt;
            flags_reg <= flags;
            lowt_reg <= lowt;
            dh_reg <= dh;
            line_reg <= line;
            for (int i = 0; i < MSG_BYTES; i++) begin
                rxbuf_reg[i] <= clear_rx ? 8'd0 : rxbuf_next[i];
            end
        end
    end

    // disabling the bus empties the transmit buffer as well
    always_ff @(posedge aclk) begin
        if (clear_rx) begin
            for (int i = 0; i < MSG_BYTES; i++) begin
                txbuf_reg[i] <= '0;
            end
        end else if (tx_wr) begin
            txbuf_reg[item.byte_index[AW-1:0]] <= item.byte_value;
        end
    end

endmodule
`default_nettype wire

// ===== sv/cec_bus_initiator_follower_unit.sv =====
// Top level of the CEC bus engine: stream ports, APB registers, request and result stages.
`default_nettype none
// Each request is taken into an input register, processed against the protocol state in
// one pass and placed in a result register, so a request can be accepted every clock;
// only a stalled result register or a register write in progress holds back input.
// Requests are events on the wire (timer expiry, captured edge) or buffer accesses.
// Registers: 0x0 bus_enable, 0x4 own_address. Write configuration only while idle.
module cec_bus_initiator_follower_unit #(
    parameter int MSG_BYTES   = 16,
    parameter int MAX_RESENDS = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[2:0], capture_ticks[18:3], bus_level[19], byte_index[23:20],
    // byte_value[31:24], msg_length[36:32], zero[39:37]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // line_level[0], timer_start[1], timer_ticks[15:2], edge_select[17:16],
    // event_code[19:18], busy_error[20], rx_length[25:21], rx_byte[33:26],
    // protocol_state[38:34], zero[39]
    output logic [39:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cecbif_pkg::*;

    item_t    in_reg;
    logic     in_valid_reg;
    result_t  out_reg;
    logic     out_valid_reg;
    result_t  res;
    logic     en_reg;
    logic [7:0] own_reg;
    logic     cfg_wr;
    logic     advance;
    cfg_cmd_t cfg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg.en_wr = cfg_wr && !paddr[2];
    assign cfg.en = pwdata[0];
    assign prdata = paddr[2] ? {24'd0, own_reg} : {31'd0, en_reg};

    assign advance = in_valid_reg && (!out_valid_reg || m_tready) && !cfg_wr;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
            own_reg <= 8'hff;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                own_reg <= pwdata[7:0];
            end else begin
                en_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= item_t'({s_tdata[2:0], s_tdata[18:3], s_tdata[19], s_tdata[23:20],
                               s_tdata[31:24], s_tdata[36:32]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    cecbif_engine #(
        .MSG_BYTES   (MSG_BYTES),
        .MAX_RESENDS (MAX_RESENDS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_reg),
        .cfg         (cfg),
        .own_address (own_reg),
        .result      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, out_reg.protocol_state, out_reg.rx_byte, out_reg.rx_length,
                      out_reg.busy_error, out_reg.event_code, out_reg.edge_select,
                      out_reg.timer_ticks, out_reg.timer_start, out_reg.line_level};

endmodule
`default_nettype wire

// ===== sim/cec_bus_checker.sv =====
// Watches the request, result and register ports of the CEC bus engine, predicts and compares.
`default_nettype none
module cec_bus_checker
    import cecbif_pkg::*;
#(
    parameter logic [2:0] ADDR_ENABLE = 3'd0,
    parameter logic [2:0] ADDR_OWN    = 3'd4,
    parameter int         MSG_BYTES   = 16,
    parameter int         MAX_RESENDS = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               errors,
    output int               pending,
    output int               n_results,
    output int               n_rx_frames,
    output int               n_tx_ok,
    output int               n_tx_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIT_T = 2400;
    localparam int TOL   = 100;

    logic       bus_en;
    logic [7:0] own_addr;
    phase_t     ph;
    logic [7:0] tx_mem [MSG_BYTES];
    logic [7:0] rx_mem [MSG_BYTES];
    int         tx_len, tx_bit, tx_byte, rx_bit, rx_byte, resends, deb_hits, low_t;
    logic       f_ack, f_pi, f_eom, f_nak;
    logic       line_drv, bus_lvl;
    logic       o_start;
    logic [1:0] o_edge, o_event;
    int         o_ticks;

    result_t    expected_q [$];

    assign pending = expected_q.size();

    task automatic report(input string fld, input int got, input int exp);
        $display("%0t: %s got %0d expected %0d", $realtime, fld, got, exp);
        errors++;
    endtask

    task automatic arm(input logic [1:0] e, input int t);
        o_start = 1'b1;
        o_edge  = e;
        o_ticks = t;
    endtask

    task automatic bump(inout int bitp, inout int bytep);
        bitp++;
        if (bitp >= 8) begin
            bitp = 0;
            if (bytep < MSG_BYTES) bytep++;
        end
    endtask

    function automatic logic tx_cur();
        if (tx_byte >= MSG_BYTES) return 1'b0;
        return tx_mem[tx_byte][7 - tx_bit];
    endfunction

    task automatic rx_put(input logic v);
        if (rx_byte < MSG_BYTES) rx_mem[rx_byte][7 - rx_bit] = v;
    endtask

    function automatic logic tx_at_eom();
        return tx_bit == 0 && tx_byte == tx_len;
    endfunction

    function automatic int lo_time(input logic one);
        return one ? 600 : 1500;
    endfunction

    function automatic int hi_time(input logic one);
        return one ? 1800 : 900;
    endfunction

    function automatic logic is_zero_lo(input int t);
        return t >= 1200 && t <= 1800;
    endfunction

    function automatic logic is_one_lo(input int t);
        return t >= 300 && t <= 900;
    endfunction

    function automatic logic data_hi_ok(input int t);
        return low_t + t >= 2050 - TOL && low_t + t <= 2750 + TOL;
    endfunction

    function automatic logic own_match();
        return {4'h0, rx_mem[0][3:0]} == own_addr;
    endfunction

    task automatic clear_all();
        line_drv = 1'b1;
        for (int i = 0; i < MSG_BYTES; i++) begin
            tx_mem[i] = '0;
            rx_mem[i] = '0;
        end
        tx_len = 0; tx_bit = 0; tx_byte = 0; rx_bit = 0; rx_byte = 0;
        resends = 0; deb_hits = 0; low_t = 0;
        {f_ack, f_pi, f_eom, f_nak} = '0;
    endtask

    task automatic enter(input int s);
        logic b;
        if (s == PH_IDLE) begin
            tx_bit = 0; tx_byte = 0; rx_bit = 0; rx_byte = 0;
            if (tx_len > 0) s = PH_WAIT_FREE;
        end
        ph = phase_t'(s);
        case (ph)
            PH_DIS: clear_all();
            PH_IDLE: begin line_drv = 1; arm(EDGE_FALL, 0); end
            PH_WAIT_FREE: begin
                line_drv = 1;
                arm(EDGE_FALL, resends != 0 ? 2 * BIT_T : f_pi ? 6 * BIT_T : 4 * BIT_T);
            end
            PH_TX_START_LO: begin
                f_pi = 1; tx_bit = 0; tx_byte = 0;
                line_drv = 0; arm(EDGE_NONE, 3700);
            end
            PH_TX_START_HI: begin line_drv = 1; arm(EDGE_FALL, 800); end
            PH_TX_INIT_LO, PH_TX_DST_LO, PH_TX_DAT_LO: begin
                line_drv = 0; arm(EDGE_NONE, lo_time(tx_cur()));
            end
            PH_TX_INIT_HI: begin line_drv = 1; arm(EDGE_FALL, hi_time(tx_cur())); end
            PH_TX_DST_HI, PH_TX_DAT_HI: begin line_drv = 1; arm(EDGE_NONE, hi_time(tx_cur())); end
            PH_TX_EOM_LO: begin line_drv = 0; arm(EDGE_NONE, lo_time(tx_at_eom())); end
            PH_TX_EOM_HI: begin line_drv = 1; arm(EDGE_NONE, hi_time(tx_at_eom())); end
            PH_TX_ACK_LO: begin line_drv = 0; arm(EDGE_NONE, 600); end
            PH_TX_ACK_WAIT: begin line_drv = 1; arm(EDGE_NONE, 450); end
            PH_TX_ACK_SMP: begin
                b = !bus_lvl;
                if (tx_mem[0][3:0] == BCAST) b = !b;
                f_ack = b;
                arm(EDGE_NONE, BIT_T - 1050);
            end
            PH_RX_START_LO: begin f_pi = 0; arm(EDGE_RISE, 3900 + TOL); end
            PH_RX_START_HI: begin deb_hits = 0; arm(EDGE_FALL, 5700 - 3500 + TOL); end
            PH_RX_DEBOUNCE: begin
                if (deb_hits >= 3) begin
                    arm(EDGE_NONE, 500);
                end else begin
                    arm(EDGE_NONE, 100);
                    deb_hits++;
                end
            end
            PH_RX_INIT_LO, PH_RX_DST_LO, PH_RX_EOM_LO, PH_RX_DAT_LO: arm(EDGE_RISE, 1700 + TOL);
            PH_RX_INIT_HI, PH_RX_DST_HI, PH_RX_EOM_HI, PH_RX_DAT_HI:
                arm(EDGE_FALL, 2750 - 400 + TOL);
            PH_RX_ACK_DRV: begin
                if (own_match()) line_drv = 0;
                arm(EDGE_NONE, 1050);
            end
            PH_RX_ACK_CHK: begin
                f_nak = rx_mem[0][3:0] == BCAST && !bus_lvl;
                arm(EDGE_NONE, 1500 - 1050);
            end
            PH_RX_ACK_DONE: begin
                line_drv = 1;
                if (f_eom || rx_byte >= MSG_BYTES) begin
                    if (own_match() || rx_mem[0][3:0] == BCAST) o_event = EV_RX_DONE;
                    arm(EDGE_NONE, 900);
                end else begin
                    arm(EDGE_FALL, 2750 - 400 + TOL);
                end
            end
            default: ;
        endcase
    endtask

    task automatic on_timer();
        case (ph)
            PH_DIS, PH_IDLE: ;
            PH_TX_INIT_HI: begin
                bump(tx_bit, tx_byte);
                enter(tx_bit == 4 ? PH_TX_DST_LO : PH_TX_INIT_LO);
            end
            PH_TX_DST_HI: begin
                bump(tx_bit, tx_byte);
                enter(tx_byte == 1 ? PH_TX_EOM_LO : PH_TX_DST_LO);
            end
            PH_TX_DAT_HI: begin
                bump(tx_bit, tx_byte);
                enter(tx_bit == 0 ? PH_TX_EOM_LO : PH_TX_DAT_LO);
            end
            PH_TX_ACK_SMP: begin
                if (f_ack) begin
                    if (!tx_at_eom()) begin
                        enter(PH_TX_DAT_LO);
                    end else begin
                        tx_len = 0; resends = 0;
                        enter(PH_IDLE); o_event = EV_TX_OK;
                    end
                end else if (resends < MAX_RESENDS) begin
                    resends++;
                    enter(PH_WAIT_FREE);
                end else begin
                    tx_len = 0; resends = 0;
                    enter(PH_IDLE); o_event = EV_TX_FAIL;
                end
            end
            PH_WAIT_FREE, PH_TX_START_LO, PH_TX_START_HI, PH_TX_INIT_LO, PH_TX_DST_LO,
            PH_TX_DAT_LO, PH_TX_EOM_LO, PH_TX_EOM_HI, PH_TX_ACK_LO, PH_TX_ACK_WAIT,
            PH_RX_ACK_DRV:
                enter(ph + 1);
            PH_RX_ACK_CHK: enter(f_nak ? PH_IDLE : PH_RX_ACK_DONE);
            default: enter(PH_IDLE);
        endcase
    endtask

    task automatic on_edge(input int t);
        case (ph)
            PH_IDLE: enter(PH_RX_START_LO);
            PH_WAIT_FREE, PH_TX_START_HI, PH_TX_INIT_HI: begin
                tx_bit = 0; tx_byte = 0;
                enter(PH_RX_START_LO);
            end
            PH_RX_START_LO: begin
                if (t >= 3500 - TOL && t <= 3900 + TOL) begin
                    low_t = t; enter(PH_RX_START_HI);
                end else if (t < 200) begin
                    enter(PH_RX_DEBOUNCE);
                end else begin
                    enter(PH_IDLE);
                end
            end
            PH_RX_START_HI:
                enter(low_t + t >= 4300 - TOL && low_t + t <= 5700 + TOL ?
                      PH_RX_INIT_LO : PH_IDLE);
            PH_RX_INIT_LO, PH_RX_DST_LO, PH_RX_DAT_LO: begin
                if (is_zero_lo(t) || is_one_lo(t)) begin
                    low_t = t;
                    rx_put(!is_zero_lo(t));
                    enter(ph + 1);
                end else begin
                    enter(PH_IDLE);
                end
            end
            PH_RX_INIT_HI, PH_RX_DST_HI, PH_RX_DAT_HI: begin
                if (data_hi_ok(t)) begin
                    bump(rx_bit, rx_byte);
                    if (ph == PH_RX_INIT_HI)
                        enter(rx_bit == 4 ? PH_RX_DST_LO : PH_RX_INIT_LO);
                    else
                        enter(rx_bit == 0 ? PH_RX_EOM_LO :
                              ph == PH_RX_DST_HI ? PH_RX_DST_LO : PH_RX_DAT_LO);
                end else begin
                    enter(PH_IDLE);
                end
            end
            PH_RX_EOM_LO: begin
                if (is_zero_lo(t) || is_one_lo(t)) begin
                    low_t = t;
                    f_eom = !is_zero_lo(t);
                    enter(PH_RX_EOM_HI);
                end else begin
                    enter(PH_IDLE);
                end
            end
            PH_RX_EOM_HI: enter(data_hi_ok(t) ? PH_RX_ACK_DRV : PH_IDLE);
            PH_RX_ACK_DRV: enter(PH_RX_ACK_DONE);
            PH_RX_ACK_DONE: enter(PH_RX_DAT_LO);
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] v);
        if (addr == ADDR_ENABLE) begin
            if (v[0] && ph == PH_DIS) enter(PH_IDLE);
            else if (!v[0] && ph != PH_DIS) enter(PH_DIS);
            bus_en = v[0];
        end else if (addr == ADDR_OWN) begin
            own_addr = v[7:0];
        end
    endtask

    task automatic take_request(input logic [39:0] d);
        logic [2:0] op;
        int         cap, idx, len;
        result_t    r;
        op = d[2:0]; cap = d[18:3]; bus_lvl = d[19]; idx = d[23:20]; len = d[36:32];
        o_start = 0; o_edge = EDGE_NONE; o_ticks = 0; o_event = EV_NONE;
        r = '0;
        case (op)
            OP_TIMER: on_timer();
            OP_EDGE: if (ph != PH_DIS) on_edge(cap);
            OP_WRITE: if (tx_len == 0 && idx < MSG_BYTES) tx_mem[idx] = d[31:24];
            OP_SEND: begin
                if (ph == PH_DIS || tx_len != 0) begin
                    r.busy_error = 1'b1;
                end else begin
                    tx_len = len > MSG_BYTES ? MSG_BYTES : len;
                    if (tx_len > 0 && ph == PH_IDLE) enter(PH_WAIT_FREE);
                end
            end
            OP_READ: if (idx < MSG_BYTES) r.rx_byte = rx_mem[idx];
            default: ;
        endcase
        r.line_level     = line_drv;
        r.timer_start    = o_start;
        r.timer_ticks    = o_start ? o_ticks[13:0] : '0;
        r.edge_select    = o_start ? o_edge : EDGE_NONE;
        r.event_code     = o_event;
        r.rx_length      = rx_byte[4:0];
        r.protocol_state = ph;
        expected_q.push_back(r);
    endtask

    task automatic check_result(input logic [39:0] d);
        result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: result with no request outstanding", $realtime);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        n_results++;
        case (e.event_code)
            EV_RX_DONE: n_rx_frames++;
            EV_TX_OK:   n_tx_ok++;
            EV_TX_FAIL: n_tx_fail++;
            default: ;
        endcase
        if (d[0] !== e.line_level) report("line_level", d[0], e.line_level);
        if (d[1] !== e.timer_start) report("timer_start", d[1], e.timer_start);
        if (d[15:2] !== e.timer_ticks) report("timer_ticks", d[15:2], e.timer_ticks);
        if (d[17:16] !== e.edge_select) report("edge_select", d[17:16], e.edge_select);
        if (d[19:18] !== e.event_code) report("event_code", d[19:18], e.event_code);
        if (d[20] !== e.busy_error) report("busy_error", d[20], e.busy_error);
        if (d[25:21] !== e.rx_length) report("rx_length", d[25:21], e.rx_length);
        if (d[33:26] !== e.rx_byte) report("rx_byte", d[33:26], e.rx_byte);
        if (d[38:34] !== e.protocol_state)
            report("protocol_state", d[38:34], e.protocol_state);
    endtask

    initial begin
        errors = 0; n_results = 0; n_rx_frames = 0; n_tx_ok = 0; n_tx_fail = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_all();
            bus_en = 0; own_addr = 8'hff; ph = PH_DIS; bus_lvl = 1;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
            if (s_tvalid && s_tready) take_request(s_tdata);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_cec_bus_initiator_follower_unit.sv =====
// Testbench top: clock, reset, register setup, request stimulus and verdict for the CEC bus engine.
`default_nettype none
module tb_cec_bus_initiator_follower_unit;
    import cecbif_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_OWN    = 3'd4;
    localparam logic [2:0] OP_UNUSED5  = 3'd5;
    localparam logic [2:0] OP_UNUSED6  = 3'd6;
    localparam logic [2:0] OP_UNUSED7  = 3'd7;
    localparam int         STALL_LIMIT = 20000;
    localparam int         ITEMS       = 700;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, n_results, n_rx_frames, n_tx_ok, n_tx_fail;
    int sent = 0;
    int s_idle_pct = 0, m_idle_pct = 0;
    int hold_seq = 0, hold_seen = 0, hold_left = 0;
    int quiet = 0;
    logic [7:0] own_cur = 8'hff;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    cec_bus_initiator_follower_unit u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    cec_bus_checker #(.ADDR_ENABLE(ADDR_ENABLE), .ADDR_OWN(ADDR_OWN)) u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .errors, .pending, .n_results, .n_rx_frames, .n_tx_ok, .n_tx_fail
    );

    // result side: random back-pressure plus a single long hold-off
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 0;
        end else begin
            m_tready = $urandom_range(99) >= m_idle_pct;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push(input logic [2:0] op, input int cap, input int lvl,
                        input int idx, input int val, input int len);
        while ($urandom_range(99) < s_idle_pct) @(negedge aclk);
        s_tvalid = 1;
        s_tdata  = {3'b000, len[4:0], val[7:0], idx[3:0], lvl[0], cap[15:0], op};
        forever begin
            #1;
            if (s_tready) break;
            @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 0;
        sent++;
    endtask

    task automatic reg_write(input logic [2:0] addr, input int v);
        @(negedge aclk);
        psel = 1; pwrite = 1; penable = 0; paddr = addr; pwdata = v;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic fill_tx();
        for (int i = 0; i < 16; i++) push(OP_WRITE, $urandom, $urandom, i, $urandom, $urandom);
    endtask

    function automatic int jitter(input int t);
        return $urandom_range(99) < 3 ? int'($urandom_range(65535)) : t;
    endfunction

    task automatic rx_bit_pair(input logic one);
        int lo;
        lo = one ? $urandom_range(300, 900) : $urandom_range(1200, 1800);
        push(OP_EDGE, jitter(lo), $urandom, $urandom, $urandom, $urandom);
        push(OP_EDGE, jitter($urandom_range(1950, 2850) - lo), $urandom, $urandom,
             $urandom, $urandom);
    endtask

    task automatic rx_frame();
        int nbytes, lo;
        logic [7:0] b;
        nbytes = $urandom_range(99) < 4 ? 18 : $urandom_range(1, 3);
        push(OP_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom);
        lo = $urandom_range(3400, 4000);
        push(OP_EDGE, jitter(lo), $urandom, $urandom, $urandom, $urandom);
        push(OP_EDGE, jitter($urandom_range(4200, 5800) - lo), $urandom, $urandom,
             $urandom, $urandom);
        for (int k = 0; k < nbytes; k++) begin
            b = 8'($urandom);
            if (k == 0) begin
                case ($urandom_range(2))
                    0: b[3:0] = own_cur[3:0];
                    1: b[3:0] = BCAST;
                    default: ;
                endcase
            end
            for (int i = 7; i >= 0; i--) rx_bit_pair(b[i]);
            rx_bit_pair(k == nbytes - 1);
            push(OP_TIMER, $urandom, $urandom, $urandom, $urandom, $urandom);
            push(OP_TIMER, $urandom, int'($urandom_range(3) != 0), $urandom, $urandom,
                 $urandom);
            if (k != nbytes - 1)
                push(OP_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        push(OP_TIMER, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 2; i++) push(OP_READ, 0, $urandom, $urandom, 0, 0);
    endtask

    task automatic tx_frame();
        int len;
        len = $urandom_range(99) < 10 ? $urandom_range(31) : $urandom_range(1, 3);
        if ($urandom_range(1)) push(OP_WRITE, $urandom, $urandom, $urandom_range(15),
                                    $urandom, $urandom);
        push(OP_SEND, $urandom, $urandom, $urandom, $urandom, len);
        for (int i = 0; i < 12 + 22 * (len > 3 ? 3 : len); i++) begin
            if ($urandom_range(99) < 2)
                push(OP_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                push(OP_TIMER, $urandom, int'($urandom_range(99) < 25), $urandom, $urandom,
                     $urandom);
        end
    endtask

    task automatic debounce_burst();
        push(OP_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 5)) begin
            push(OP_EDGE, $urandom_range(199), $urandom, $urandom, $urandom, $urandom);
            push(OP_TIMER, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1;
        s_idle_pct = 17; m_idle_pct = 54;

        // disabled engine: reads, unknown ops, refused send, ignored events
        push(OP_READ, 0, 0, 0, 0, 0);
        push(OP_READ, 65535, 1, 15, 255, 31);
        push(OP_UNUSED5, 65535, 1, 15, 255, 31);
        push(OP_UNUSED6, 0, 0, 0, 0, 0);
        push(OP_UNUSED7, 12345, 1, 7, 170, 16);
        push(OP_SEND, 0, 0, 0, 0, 5);
        push(OP_TIMER, 0, 0, 0, 0, 0);
        push(OP_EDGE, 3700, 1, 0, 0, 0);
        drain();
        own_cur = 8'h04;
        reg_write(ADDR_OWN, int'(own_cur));
        reg_write(ADDR_ENABLE, 1);
        fill_tx();
        push(OP_WRITE, 0, 0, 0, 8'h4f, 0);
        push(OP_SEND, 0, 0, 0, 0, 0);
        push(OP_SEND, 0, 0, 0, 0, 31);
        push(OP_SEND, 0, 0, 0, 0, 1);
        push(OP_WRITE, 0, 0, 0, 8'h00, 0);

        for (int mode = 0; mode < 3; mode++) begin
            s_idle_pct = mode == 0 ? 17 : mode == 1 ? 54 : 0;
            m_idle_pct = mode == 0 ? 54 : mode == 1 ? 17 : 0;
            while (sent < ITEMS * (mode + 1) / 3) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: rx_frame();
                    4, 5, 6: tx_frame();
                    7: debounce_burst();
                    default: push(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
                endcase
                if (mode == 0 && hold_seq == 0 && sent > 120) hold_seq++;
            end
            drain();
            reg_write(ADDR_ENABLE, 0);
            push(OP_READ, 0, 0, 3, 0, 0);
            drain();
            own_cur = mode == 0 ? 8'hff : mode == 1 ? 8'h00 : 8'($urandom);
            reg_write(ADDR_OWN, int'(own_cur));
            reg_write(ADDR_ENABLE, 1);
            fill_tx();
        end

        drain();
        repeat (20) @(negedge aclk);
        $display("Run: %0d requests, %0d results checked; frames received %0d,",
                 sent, n_results, n_rx_frames);
        $display("sends ok %0d, sends failed %0d, under three back-pressure mixes",
                 n_tx_ok, n_tx_fail);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
